// ----- design/integer_matrix_multiply_unit_defines.svh -----
// ----------------------------------------------------------------------------
// Integer matrix multiply unit: assertion macros
// Shared property shorthands for the checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH
`define INTEGER_MATRIX_MULTIPLY_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMM_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/imm_pkg.sv -----
// ----------------------------------------------------------------------------
// imm_pkg
// Types, codes and helper functions of the integer matrix multiply unit.
// ----------------------------------------------------------------------------
package imm_pkg;

  localparam int unsigned DATA_W      = 32;
  localparam int unsigned IDX_W       = 3;
  localparam int unsigned DIM_W       = 4;
  localparam int unsigned REQ_W       = 2;
  localparam int unsigned ST_W        = 2;
  localparam int unsigned APB_AW      = 4;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned MAX_DIM_DEF = 8;

  localparam logic [DIM_W-1:0] CFG_RESET = DIM_W'(8);

  // Request codes.
  localparam logic [REQ_W-1:0] REQ_WR_A = 2'd0;
  localparam logic [REQ_W-1:0] REQ_WR_B = 2'd1;
  localparam logic [REQ_W-1:0] REQ_RD_C = 2'd2;

  // Response status codes.
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_MISMATCH = 2'd1;
  localparam logic [ST_W-1:0] ST_RANGE    = 2'd2;

  // Register indexes (byte address bits [3:2]).
  localparam logic [1:0] REG_A_ROWS = 2'd0;
  localparam logic [1:0] REG_A_COLS = 2'd1;
  localparam logic [1:0] REG_B_ROWS = 2'd2;
  localparam logic [1:0] REG_B_COLS = 2'd3;

  typedef struct packed {
    logic [DIM_W-1:0] a_rows;
    logic [DIM_W-1:0] a_cols;
    logic [DIM_W-1:0] b_rows;
    logic [DIM_W-1:0] b_cols;
  } cfg_t;

  typedef struct packed {
    logic             capture;
    logic             wr_a;
    logic             wr_b;
    logic             issue;
    logic [DIM_W-1:0] k;
    logic             load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic [ST_W-1:0]  chk_status;
    logic [DIM_W-1:0] inner;
    logic             busy;
    logic             out_full;
  } dp_sts_t;

  // Size register saturated to the store dimension.
  function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] r,
                                               input int unsigned max_dim);
    return (32'(r) > max_dim) ? DIM_W'(max_dim) : r;
  endfunction

endpackage

// ----- design/imm_req_if.sv -----
// ----------------------------------------------------------------------------
// imm_req_if
// Request channel: element writes to A or B and product element reads.
// ----------------------------------------------------------------------------
interface imm_req_if;
  logic                              valid;
  logic                              ready;
  logic [imm_pkg::REQ_W-1:0]         req_type;
  logic [imm_pkg::IDX_W-1:0]         row_index;
  logic [imm_pkg::IDX_W-1:0]         col_index;
  logic signed [imm_pkg::DATA_W-1:0] elem_value;

  modport source (output valid, req_type, row_index, col_index, elem_value,
                  input ready);
  modport sink (input valid, req_type, row_index, col_index, elem_value,
                output ready);
endinterface

// ----- design/imm_rsp_if.sv -----
// ----------------------------------------------------------------------------
// imm_rsp_if
// Response channel: one product element and its status per read.
// ----------------------------------------------------------------------------
interface imm_rsp_if;
  logic                              valid;
  logic                              ready;
  logic signed [imm_pkg::DATA_W-1:0] product_value;
  logic [imm_pkg::ST_W-1:0]          status;

  modport source (output valid, product_value, status, input ready);
  modport sink (input valid, product_value, status, output ready);
endinterface

// ----- design/imm_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// imm_cfg_regs
// APB register file holding the four matrix size registers.
// ----------------------------------------------------------------------------
module imm_cfg_regs (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [imm_pkg::APB_AW-1:0]   paddr,
  input  logic [imm_pkg::APB_DW-1:0]   pwdata,
  output logic [imm_pkg::APB_DW-1:0]   prdata,
  output logic                         pready,
  output imm_pkg::cfg_t                cfg_o
);

  imm_pkg::cfg_t    cfg_q;
  logic             wr_en;
  logic [1:0]       reg_sel;
  logic [imm_pkg::DIM_W-1:0] wr_val;
  logic [imm_pkg::DIM_W-1:0] rd_val;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_sel = paddr[3:2];
  assign wr_val  = pwdata[imm_pkg::DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.a_rows <= imm_pkg::CFG_RESET;
      cfg_q.a_cols <= imm_pkg::CFG_RESET;
      cfg_q.b_rows <= imm_pkg::CFG_RESET;
      cfg_q.b_cols <= imm_pkg::CFG_RESET;
    end else if (wr_en) begin
      unique case (reg_sel)
        imm_pkg::REG_A_ROWS: cfg_q.a_rows <= wr_val;
        imm_pkg::REG_A_COLS: cfg_q.a_cols <= wr_val;
        imm_pkg::REG_B_ROWS: cfg_q.b_rows <= wr_val;
        imm_pkg::REG_B_COLS: cfg_q.b_cols <= wr_val;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      imm_pkg::REG_A_ROWS: rd_val = cfg_q.a_rows;
      imm_pkg::REG_A_COLS: rd_val = cfg_q.a_cols;
      imm_pkg::REG_B_ROWS: rd_val = cfg_q.b_rows;
      imm_pkg::REG_B_COLS: rd_val = cfg_q.b_cols;
      default:             rd_val = '0;
    endcase
  end

  assign prdata = {{(imm_pkg::APB_DW - imm_pkg::DIM_W){1'b0}}, rd_val};
  assign cfg_o  = cfg_q;

endmodule

// ----- design/imm_ctrl.sv -----
// ----------------------------------------------------------------------------
// imm_ctrl
// Sequencer: accepts requests, steps the inner index and hands results out.
// ----------------------------------------------------------------------------
module imm_ctrl (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  input  logic [imm_pkg::REQ_W-1:0]  in_req_type_i,
  output logic                       in_ready_o,
  input  imm_pkg::dp_sts_t           sts_i,
  output imm_pkg::dp_cmd_t           cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MAC,
    S_FLUSH,
    S_RESP
  } state_e;

  state_e                    state_q;
  logic [imm_pkg::DIM_W-1:0] k_q;
  logic                      accept;
  logic                      rd_accept;
  logic                      last_k;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i & in_ready_o;
  assign rd_accept  = accept & (in_req_type_i == imm_pkg::REQ_RD_C);
  assign last_k     = ((k_q + imm_pkg::DIM_W'(1)) == sts_i.inner);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      k_q     <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (rd_accept) begin
            k_q <= '0;
            // Errors and an empty inner size skip the multiply loop.
            if ((sts_i.chk_status != imm_pkg::ST_OK) || (sts_i.inner == '0)) begin
              state_q <= S_RESP;
            end else begin
              state_q <= S_MAC;
            end
          end
        end
        S_MAC: begin
          k_q <= k_q + imm_pkg::DIM_W'(1);
          if (last_k) begin
            state_q <= S_FLUSH;
          end
        end
        S_FLUSH: begin
          if (!sts_i.busy) begin
            state_q <= S_RESP;
          end
        end
        S_RESP: begin
          if (!sts_i.out_full) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o.capture  = rd_accept;
    cmd_o.wr_a     = accept & (in_req_type_i == imm_pkg::REQ_WR_A);
    cmd_o.wr_b     = accept & (in_req_type_i == imm_pkg::REQ_WR_B);
    cmd_o.issue    = (state_q == S_MAC);
    cmd_o.k        = k_q;
    cmd_o.load_out = (state_q == S_RESP) & ~sts_i.out_full;
  end

endmodule

// ----- design/imm_datapath.sv -----
// ----------------------------------------------------------------------------
// imm_datapath
// Operand stores, multiply-accumulate pipeline and the response register.
// ----------------------------------------------------------------------------
module imm_datapath #(
  parameter int unsigned MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  imm_pkg::cfg_t                     cfg_i,
  input  imm_pkg::dp_cmd_t                  cmd_i,
  output imm_pkg::dp_sts_t                  sts_o,
  input  logic [imm_pkg::IDX_W-1:0]         row_i,
  input  logic [imm_pkg::IDX_W-1:0]         col_i,
  input  logic signed [imm_pkg::DATA_W-1:0] value_i,
  imm_rsp_if.source                         rsp
);

  localparam int unsigned Depth = MAX_DIM * MAX_DIM;
  localparam int unsigned AW    = $clog2(Depth);

  logic [imm_pkg::DATA_W-1:0] a_mem [Depth];
  logic [imm_pkg::DATA_W-1:0] b_mem [Depth];

  logic [imm_pkg::IDX_W-1:0]  row_q, col_q;
  logic [imm_pkg::ST_W-1:0]   stat_q;
  logic [imm_pkg::DATA_W-1:0] a_rd_q, b_rd_q, prod_q, acc_q;
  logic                       vld1_q, vld2_q;
  logic                       out_valid_q;
  logic [imm_pkg::DATA_W-1:0] out_value_q;
  logic [imm_pkg::ST_W-1:0]   out_status_q;

  logic                       wr_in_range;
  logic [AW-1:0]              wr_addr, a_raddr, b_raddr;
  logic [imm_pkg::DIM_W-1:0]  eff_rows, eff_cols;
  logic [imm_pkg::ST_W-1:0]   chk_status;

  // Writes beyond the store are dropped; those beyond the sizes in use are kept.
  assign wr_in_range = (32'(row_i) < MAX_DIM) && (32'(col_i) < MAX_DIM);
  assign wr_addr     = AW'(32'(row_i) * MAX_DIM + 32'(col_i));
  assign a_raddr     = AW'(32'(row_q) * MAX_DIM + 32'(cmd_i.k));
  assign b_raddr     = AW'(32'(cmd_i.k) * MAX_DIM + 32'(col_q));

  assign eff_rows = imm_pkg::eff_dim(cfg_i.a_rows, MAX_DIM);
  assign eff_cols = imm_pkg::eff_dim(cfg_i.b_cols, MAX_DIM);

  // The dimension mismatch check uses the raw register values and wins.
  always_comb begin
    priority if (cfg_i.a_cols != cfg_i.b_rows) begin
      chk_status = imm_pkg::ST_MISMATCH;
    end else if (({1'b0, row_i} >= eff_rows) || ({1'b0, col_i} >= eff_cols)) begin
      chk_status = imm_pkg::ST_RANGE;
    end else begin
      chk_status = imm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_a && wr_in_range) begin
      a_mem[wr_addr] <= value_i;
    end
    a_rd_q <= a_mem[a_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_b && wr_in_range) begin
      b_mem[wr_addr] <= value_i;
    end
    b_rd_q <= b_mem[b_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      row_q  <= row_i;
      col_q  <= col_i;
      stat_q <= chk_status;
    end
    prod_q <= a_rd_q * b_rd_q;
    if (cmd_i.capture) begin
      acc_q <= '0;
    end else if (vld2_q) begin
      acc_q <= acc_q + prod_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q      <= 1'b0;
      vld2_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      vld1_q <= cmd_i.issue;
      vld2_q <= vld1_q;
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_value_q  <= acc_q;
      out_status_q <= stat_q;
    end
  end

  assign rsp.valid         = out_valid_q;
  assign rsp.product_value = out_value_q;
  assign rsp.status        = out_status_q;

  always_comb begin
    sts_o.chk_status = chk_status;
    sts_o.inner      = imm_pkg::eff_dim(cfg_i.a_cols, MAX_DIM);
    sts_o.busy       = vld1_q | vld2_q;
    sts_o.out_full   = out_valid_q & ~rsp.ready;
  end

endmodule

// ----- design/integer_matrix_multiply_unit.sv -----
// ----------------------------------------------------------------------------
// integer_matrix_multiply_unit
// Signed 32-bit matrix multiplier with on-chip A and B stores; reads return
// one element of the product.
// ----------------------------------------------------------------------------
// Channel    Dir  Handshake        Carries
// req_chan   in   valid/ready      req_type, row_index, col_index, elem_value
// rsp_chan   out  valid/ready      product_value, status
// APB        in   psel/penable     a_rows, a_cols, b_rows, b_cols
//
// A read steps through inner, the saturated a_cols: one multiply-accumulate
// per cycle through the single read port of each store, then a drain through
// the read and multiply stages. Error reads skip the loop. Reset clears control
// state only; store entries stay undefined until written. A result waiting on
// rsp_chan does not block further writes; a following read waits for the
// response register to empty.
// ----------------------------------------------------------------------------
`include "integer_matrix_multiply_unit_defines.svh"

module integer_matrix_multiply_unit #(
  parameter int unsigned MAX_DIM = imm_pkg::MAX_DIM_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  imm_req_if.sink                    req_chan,
  imm_rsp_if.source                  rsp_chan,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [imm_pkg::APB_AW-1:0] paddr,
  input  logic [imm_pkg::APB_DW-1:0] pwdata,
  output logic [imm_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  imm_pkg::cfg_t    cfg;
  imm_pkg::dp_cmd_t dp_cmd;
  imm_pkg::dp_sts_t dp_sts;

  imm_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  imm_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (req_chan.valid),
    .in_req_type_i (req_chan.req_type),
    .in_ready_o    (req_chan.ready),
    .sts_i         (dp_sts),
    .cmd_o         (dp_cmd)
  );

  imm_datapath #(
    .MAX_DIM (MAX_DIM)
  ) u_dp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .cmd_i   (dp_cmd),
    .sts_o   (dp_sts),
    .row_i   (req_chan.row_index),
    .col_i   (req_chan.col_index),
    .value_i (req_chan.elem_value),
    .rsp     (rsp_chan)
  );

  // The accumulator is final only once the multiply pipeline has drained.
  `IMM_ASSERT_SAME(a_load_drained, clk_i, rst_ni, dp_cmd.load_out, !dp_sts.busy, "result loaded before pipeline drained")
  // No request is taken while multiply-accumulates are being issued.
  `IMM_ASSERT_SAME(a_no_accept_in_mac, clk_i, rst_ni, dp_cmd.issue, !req_chan.ready, "request accepted during MAC loop")
  // A loaded result must appear on the response channel in the next cycle.
  `IMM_ASSERT_NEXT(a_load_shows, clk_i, rst_ni, dp_cmd.load_out, rsp_chan.valid, "loaded result not presented")
  // Error responses carry a zero product.
  `IMM_ASSERT_SAME(a_err_zero, clk_i, rst_ni, rsp_chan.valid && (rsp_chan.status != imm_pkg::ST_OK), rsp_chan.product_value == '0, "error response with nonzero product")

endmodule

// ----- dv/integer_matrix_multiply_unit_checker.sv -----
// ----------------------------------------------------------------------------
// Integer matrix multiply unit: product checker
// Watches the request, response and register channels. It keeps its own copy
// of both operand stores and of the size registers, and predicts every product
// read. Each response is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit_checker
  import imm_pkg::*;
#(
  parameter int unsigned MAX_DIM = MAX_DIM_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  imm_req_if                req_mon,
  imm_rsp_if                rsp_mon,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output int unsigned       mismatches,
  output int unsigned       outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [ST_W-1:0]          status;
  } product_t;

  logic signed [DATA_W-1:0] a_mem [MAX_DIM*MAX_DIM];
  logic signed [DATA_W-1:0] b_mem [MAX_DIM*MAX_DIM];
  cfg_t                     dims;
  product_t                 product_q [$];

  function automatic int unsigned sat_dim(input logic [DIM_W-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : int'(r);
  endfunction

  function automatic product_t multiply_element(input logic [IDX_W-1:0] row,
                                                input logic [IDX_W-1:0] col);
    product_t          res;
    logic [DATA_W-1:0] acc;
    int unsigned       inner;
    res.value  = '0;
    res.status = ST_OK;
    acc        = '0;
    // The size match is judged on the raw register values, before saturation.
    if (dims.a_cols != dims.b_rows) begin
      res.status = ST_MISMATCH;
    end else if (row >= sat_dim(dims.a_rows) || col >= sat_dim(dims.b_cols)) begin
      res.status = ST_RANGE;
    end else begin
      inner = sat_dim(dims.a_cols);
      for (int k = 0; k < inner; k++) begin
        acc += a_mem[row*MAX_DIM + k] * b_mem[k*MAX_DIM + col];
      end
      res.value = acc;
    end
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    product_t    got;
    product_t    want;
    logic        in_store;
    int unsigned addr;
    if (!rst_ni) begin
      dims        = '{CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET};
      product_q.delete();
      mismatches  = 0;
      outstanding = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_A_ROWS: dims.a_rows = pwdata[DIM_W-1:0];
          REG_A_COLS: dims.a_cols = pwdata[DIM_W-1:0];
          REG_B_ROWS: dims.b_rows = pwdata[DIM_W-1:0];
          REG_B_COLS: dims.b_cols = pwdata[DIM_W-1:0];
          default: ;
        endcase
      end

      // Responses are handled before new requests so that a read accepted in
      // the same cycle lines up behind the ones already waiting.
      if (rsp_mon.valid && rsp_mon.ready) begin
        got.value  = rsp_mon.product_value;
        got.status = rsp_mon.status;
        if (product_q.size() == 0) begin
          $display("%0t: unexpected product transaction expected none actual %h status %0d",
                   $time, got.value, got.status);
          mismatches++;
        end else begin
          want = product_q.pop_front();
          if (got.value !== want.value) begin
            $display("%0t: product_value mismatch expected %h actual %h",
                     $time, want.value, got.value);
            mismatches++;
          end
          if (got.status !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, got.status);
            mismatches++;
          end
        end
      end

      if (req_mon.valid && req_mon.ready) begin
        // Writes that fall outside the store are dropped.
        in_store = (req_mon.row_index < MAX_DIM) && (req_mon.col_index < MAX_DIM);
        addr     = req_mon.row_index*MAX_DIM + req_mon.col_index;
        case (req_mon.req_type)
          REQ_WR_A: if (in_store) a_mem[addr] = req_mon.elem_value;
          REQ_WR_B: if (in_store) b_mem[addr] = req_mon.elem_value;
          REQ_RD_C: product_q.push_back(multiply_element(req_mon.row_index,
                                                         req_mon.col_index));
          default: ;
        endcase
      end
      outstanding = product_q.size();
    end
  end

endmodule

// ----- dv/integer_matrix_multiply_unit_tb.sv -----
// ----------------------------------------------------------------------------
// Integer matrix multiply unit: testbench top
// Drives element writes, product reads and size register writes, with random
// gaps on the request side and random stalls on the response side. The
// product checker beside the block predicts and compares every read.
// ----------------------------------------------------------------------------
module integer_matrix_multiply_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import imm_pkg::*;

  localparam int unsigned     MAX_DIM      = MAX_DIM_DEF;
  localparam int unsigned     SETTLE_CYCLES = 2*MAX_DIM + 8;
  localparam int unsigned     SEGMENT_ITEMS = 46;
  localparam logic [REQ_W-1:0] REQ_NONE    = 2'd3;

  logic              clk_i;
  logic              rst_ni;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  imm_req_if req_if ();
  imm_rsp_if rsp_if ();

  cfg_t        dims_now;
  bit          a_written [MAX_DIM*MAX_DIM];
  bit          b_written [MAX_DIM*MAX_DIM];
  int unsigned gap_pct;
  int unsigned stall_pct;
  int unsigned issued;
  int unsigned mismatches;
  int unsigned outstanding;

  integer_matrix_multiply_unit #(.MAX_DIM(MAX_DIM)) dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_chan (req_if),
    .rsp_chan (rsp_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  integer_matrix_multiply_unit_checker #(.MAX_DIM(MAX_DIM)) product_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_mon     (req_if),
    .rsp_mon     (rsp_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  always #4 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rsp_if.ready = ($urandom_range(99) >= stall_pct);
  end

  initial begin
    #5_000_000;
    $display("integer_matrix_multiply_unit_tb: FAIL");
    $finish;
  end

  function automatic int unsigned sat_dim(input logic [DIM_W-1:0] r);
    return (r > MAX_DIM) ? MAX_DIM : int'(r);
  endfunction

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(7))
      0:       return 32'sd0;
      1:       return 32'sd1;
      2:       return -32'sd1;
      3:       return 32'sh8000_0000;
      4:       return 32'sh7fff_ffff;
      5:       return $signed($urandom_range(200)) - 32'sd100;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [DIM_W-1:0] pick_dim();
    case ($urandom_range(11))
      0:       return '0;
      1:       return DIM_W'($urandom_range(9, 15));
      2:       return DIM_W'(MAX_DIM);
      3:       return DIM_W'(1);
      default: return DIM_W'($urandom_range(1, MAX_DIM));
    endcase
  endfunction

  // Mostly inside the configured size, sometimes anywhere in the store.
  function automatic logic [IDX_W-1:0] pick_index(input int unsigned limit);
    if (limit == 0 || $urandom_range(4) == 0) return IDX_W'($urandom_range(7));
    return IDX_W'($urandom_range(limit - 1));
  endfunction

  task automatic issue_request(input logic [REQ_W-1:0]  kind,
                               input logic [IDX_W-1:0]  row,
                               input logic [IDX_W-1:0]  col,
                               input logic signed [DATA_W-1:0] val);
    while ($urandom_range(99) < gap_pct) begin
      req_if.valid = 1'b0;
      @(negedge clk_i);
    end
    req_if.valid      = 1'b1;
    req_if.req_type   = kind;
    req_if.row_index  = row;
    req_if.col_index  = col;
    req_if.elem_value = val;
    do @(posedge clk_i); while (req_if.ready !== 1'b1);
    @(negedge clk_i);
    if (kind != REQ_NONE) issued++;
    if (kind == REQ_WR_A) a_written[row*MAX_DIM + col] = 1'b1;
    if (kind == REQ_WR_B) b_written[row*MAX_DIM + col] = 1'b1;
  endtask

  // Any operand that the read would use and that was never written is
  // written first, so the block never sums an undefined store entry.
  task automatic read_product(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col);
    int unsigned inner;
    if (dims_now.a_cols == dims_now.b_rows && row < sat_dim(dims_now.a_rows)
        && col < sat_dim(dims_now.b_cols)) begin
      inner = sat_dim(dims_now.a_cols);
      for (int k = 0; k < inner; k++) begin
        if (!a_written[row*MAX_DIM + k]) issue_request(REQ_WR_A, row, IDX_W'(k), pick_value());
        if (!b_written[k*MAX_DIM + col]) issue_request(REQ_WR_B, IDX_W'(k), col, pick_value());
      end
    end
    issue_request(REQ_RD_C, row, col, $urandom());
  endtask

  task automatic wait_drained();
    req_if.valid = 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] val);
    psel       = 1'b1;
    penable    = 1'b0;
    pwrite     = 1'b1;
    paddr      = {idx, 2'b00};
    pwdata     = $urandom();
    pwdata[DIM_W-1:0] = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    case (idx)
      REG_A_ROWS: dims_now.a_rows = val;
      REG_A_COLS: dims_now.a_cols = val;
      REG_B_ROWS: dims_now.b_rows = val;
      REG_B_COLS: dims_now.b_cols = val;
      default: ;
    endcase
  endtask

  task automatic program_dims(input logic [DIM_W-1:0] ar, input logic [DIM_W-1:0] ac,
                              input logic [DIM_W-1:0] br, input logic [DIM_W-1:0] bc);
    wait_drained();
    write_reg(REG_A_ROWS, ar);
    write_reg(REG_A_COLS, ac);
    write_reg(REG_B_ROWS, br);
    write_reg(REG_B_COLS, bc);
  endtask

  initial begin
    int unsigned      target;
    int unsigned      sel;
    logic [DIM_W-1:0] ac;
    clk_i              = 1'b0;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    req_if.valid       = 1'b0;
    req_if.req_type    = REQ_WR_A;
    req_if.row_index   = '0;
    req_if.col_index   = '0;
    req_if.elem_value  = '0;
    rsp_if.ready       = 1'b0;
    gap_pct            = 0;
    stall_pct          = 0;
    issued             = 0;
    dims_now           = '{CFG_RESET, CFG_RESET, CFG_RESET, CFG_RESET};
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: a 2x2 product with the signed extremes as operands.
    program_dims(4'd2, 4'd2, 4'd2, 4'd2);
    issue_request(REQ_WR_A, 3'd0, 3'd0, 32'sh7fff_ffff);
    issue_request(REQ_WR_A, 3'd0, 3'd1, 32'sh8000_0000);
    issue_request(REQ_WR_A, 3'd1, 3'd0, -32'sd1);
    issue_request(REQ_WR_A, 3'd1, 3'd1, 32'sd0);
    issue_request(REQ_WR_B, 3'd0, 3'd0, -32'sd1);
    issue_request(REQ_WR_B, 3'd1, 3'd0, 32'sh8000_0000);
    issue_request(REQ_WR_B, 3'd0, 3'd1, 32'sd1);
    issue_request(REQ_WR_B, 3'd1, 3'd1, 32'sh7fff_ffff);
    read_product(3'd0, 3'd0);
    read_product(3'd0, 3'd1);
    read_product(3'd1, 3'd0);
    read_product(3'd1, 3'd1);
    read_product(3'd2, 3'd0);
    read_product(3'd0, 3'd2);
    read_product(3'd7, 3'd7);
    issue_request(REQ_NONE, 3'd7, 3'd7, 32'shffff_ffff);
    // Writes outside the configured size still land in the store.
    issue_request(REQ_WR_A, 3'd7, 3'd7, 32'sh8000_0001);
    issue_request(REQ_WR_B, 3'd7, 3'd7, 32'sh7fff_fffe);
    program_dims(4'd2, 4'd3, 4'd2, 4'd2);
    read_product(3'd0, 3'd0);
    // Saturated sizes agree but the raw registers do not.
    program_dims(4'd8, 4'd8, 4'd15, 4'd8);
    read_product(3'd1, 3'd1);
    program_dims(4'd0, 4'd2, 4'd2, 4'd2);
    read_product(3'd0, 3'd0);
    program_dims(4'd2, 4'd2, 4'd2, 4'd0);
    read_product(3'd0, 3'd0);
    program_dims(4'd2, 4'd0, 4'd0, 4'd2);
    read_product(3'd1, 3'd1);
    program_dims(4'd15, 4'd15, 4'd15, 4'd15);
    read_product(3'd7, 3'd7);
    read_product(3'd0, 3'd0);

    // Random: four idling phases, three size settings in each.
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 64; stall_pct = 0;  end
        2:       begin gap_pct = 0;  stall_pct = 64; end
        default: begin gap_pct = 19; stall_pct = 19; end
      endcase
      for (int seg = 0; seg < 3; seg++) begin
        ac = pick_dim();
        program_dims(pick_dim(), ac, ($urandom_range(4) == 0) ? pick_dim() : ac, pick_dim());
        target = issued + SEGMENT_ITEMS;
        while (issued < target) begin
          sel = $urandom_range(99);
          if (sel < 3) begin
            wait_drained();
          end else if (sel < 8) begin
            issue_request(REQ_NONE, IDX_W'($urandom()), IDX_W'($urandom()), $urandom());
          end else if (sel < 50) begin
            read_product(pick_index(sat_dim(dims_now.a_rows)),
                         pick_index(sat_dim(dims_now.b_cols)));
          end else begin
            issue_request($urandom_range(1) ? REQ_WR_A : REQ_WR_B, IDX_W'($urandom()),
                          IDX_W'($urandom()), pick_value());
          end
        end
      end
    end

    wait_drained();
    if (mismatches == 0) begin
      $display("integer_matrix_multiply_unit_tb: PASS");
    end else begin
      $display("integer_matrix_multiply_unit_tb: FAIL");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/imm_pkg.sv
design/imm_req_if.sv
design/imm_rsp_if.sv
design/imm_cfg_regs.sv
design/imm_ctrl.sv
design/imm_datapath.sv
design/integer_matrix_multiply_unit.sv
dv/integer_matrix_multiply_unit_checker.sv
dv/integer_matrix_multiply_unit_tb.sv
